// ===== rtl/core/hlfd_pkg.sv =====
// ----------------------------------------------------------------------------
// hlfd_pkg
// Shared types, event codes and the hex digit decoder of the length-prefixed
// frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hlfd_pkg;

	localparam int BYTE_W   = 8;
	localparam int LENGTH_W = 16;
	localparam int NIBBLE_W = 4;
	localparam int EVENT_W  = 2;

	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [LENGTH_W-1:0] length_t;
	typedef logic [NIBBLE_W-1:0] nibble_t;
	typedef logic [EVENT_W-1:0]  event_kind_t;

	// Event codes carried on event_kind.
	localparam event_kind_t EV_PAYLOAD = 2'd0;
	localparam event_kind_t EV_EMPTY   = 2'd1;
	localparam event_kind_t EV_CORRUPT = 2'd2;

	// Result of decoding one header byte.
	typedef struct packed {
		logic    bad;
		nibble_t value;
	} hex_digit_t;

	// Decode an ASCII hex digit; a non-hex byte flags bad and reads as zero.
	function automatic hex_digit_t hex_decode(input byte_t b);
		hex_digit_t d;
		d.bad   = 1'b0;
		d.value = '0;
		if (b >= 8'h30 && b <= 8'h39) begin
			d.value = NIBBLE_W'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			d.value = NIBBLE_W'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			d.value = NIBBLE_W'(b - 8'h37);
		end else begin
			d.bad = 1'b1;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hex_length_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// hex_length_frame_deframer
// Byte-serial deframer for frames prefixed by an ASCII hex length header.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake           | Payload                               | Dir
//  ---------+---------------------+---------------------------------------+----
//  input    | in_valid / in_stall | data_byte, chunk_end                  | in
//  result   | out_valid/out_stall | payload_byte, frame_last, event_kind  | out
//  config   | cfg_wr_en           | cfg_wr_data (framing_enable)          | in
//
//  One item per cycle sustained while out_stall is low. An accepted byte
//  lands in the input register, is decoded against the parser state in one
//  pass, and its result (if any) is written to the output register when that
//  register is free; out_valid then rises.
//  arst_n clears the parser to "expecting header" with framing off.
//  A stalled result holds the output register; the input register then
//  holds its byte, and in_stall rises only while both are full.
//
`default_nettype none

module hex_length_frame_deframer #(
	parameter int HEADER_DIGITS = 4
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// input channel
	input  wire logic                     in_valid,
	output      logic                     in_stall,
	input  wire hlfd_pkg::byte_t          data_byte,
	input  wire logic                     chunk_end,
	// result channel
	output      logic                     out_valid,
	input  wire logic                     out_stall,
	output      hlfd_pkg::byte_t          payload_byte,
	output      logic                     frame_last,
	output      hlfd_pkg::event_kind_t    event_kind,
	// configuration
	input  wire logic                     cfg_wr_en,
	input  wire logic                     cfg_wr_data
);

	// Header digit counter only has to reach HEADER_DIGITS-1.
	localparam int DIGIT_W = (HEADER_DIGITS > 1) ? $clog2(HEADER_DIGITS) : 1;
	localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(HEADER_DIGITS - 1);

	// Input register
	logic            valid_s1;
	hlfd_pkg::byte_t byte_s1;
	logic            cend_s1;

	// Parser state
	logic                 framing_q;
	logic                 expect_header_q;
	logic [DIGIT_W-1:0]   digits_q;
	hlfd_pkg::length_t    accum_q;
	logic                 invalid_q;
	hlfd_pkg::length_t    remaining_q;

	// Output register
	logic                  out_valid_q;
	hlfd_pkg::byte_t       out_byte_q;
	logic                  out_last_q;
	hlfd_pkg::event_kind_t out_kind_q;

	// Next-state and result of the byte in the input register
	logic                  advance;
	logic                  accept;
	hlfd_pkg::hex_digit_t  digit;
	hlfd_pkg::length_t     accum_shift;
	logic                  invalid_new;
	logic                  emit_c;
	hlfd_pkg::byte_t       res_byte_c;
	logic                  res_last_c;
	hlfd_pkg::event_kind_t res_kind_c;
	logic                  expect_header_d;
	logic [DIGIT_W-1:0]    digits_d;
	hlfd_pkg::length_t     accum_d;
	logic                  invalid_d;
	hlfd_pkg::length_t     remaining_d;

	// Output register frees up when empty or being taken this edge.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign digit       = hlfd_pkg::hex_decode(byte_s1);
	assign accum_shift = {accum_q[hlfd_pkg::LENGTH_W-hlfd_pkg::NIBBLE_W-1:0], digit.value};
	assign invalid_new = invalid_q | digit.bad;

	always_comb begin
		expect_header_d = expect_header_q;
		digits_d        = digits_q;
		accum_d         = accum_q;
		invalid_d       = invalid_q;
		remaining_d     = remaining_q;
		emit_c          = 1'b0;
		res_byte_c      = '0;
		res_last_c      = 1'b0;
		res_kind_c      = hlfd_pkg::EV_PAYLOAD;

		if (!framing_q) begin
			// Unframed: pass the byte, chunk end marks the last one.
			emit_c     = 1'b1;
			res_byte_c = byte_s1;
			res_last_c = cend_s1;
		end else if (expect_header_q) begin
			if (digits_q != LAST_DIGIT) begin
				// Header still collecting: advance count, no result.
				digits_d  = digits_q + DIGIT_W'(1);
				accum_d   = accum_shift;
				invalid_d = invalid_new;
			end else begin
				// Header complete: drop it in every case.
				digits_d  = '0;
				accum_d   = '0;
				invalid_d = 1'b0;
				if (invalid_new) begin
					emit_c     = 1'b1;
					res_kind_c = hlfd_pkg::EV_CORRUPT;
				end else if (accum_shift == '0) begin
					emit_c     = 1'b1;
					res_kind_c = hlfd_pkg::EV_EMPTY;
				end else begin
					remaining_d     = accum_shift;
					expect_header_d = 1'b0;
				end
			end
		end else begin
			emit_c     = 1'b1;
			res_byte_c = byte_s1;
			if (remaining_q <= hlfd_pkg::LENGTH_W'(1)) begin
				// Final payload byte: go back to header parsing.
				res_last_c      = 1'b1;
				remaining_d     = '0;
				expect_header_d = 1'b1;
				digits_d        = '0;
				accum_d         = '0;
				invalid_d       = 1'b0;
			end else begin
				remaining_d = remaining_q - hlfd_pkg::LENGTH_W'(1);
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			cend_s1 <= chunk_end;
		end
	end

	// Parser state; the user must write configuration only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framing_q       <= 1'b0;
			expect_header_q <= 1'b1;
			digits_q        <= '0;
			accum_q         <= '0;
			invalid_q       <= 1'b0;
			remaining_q     <= '0;
		end else if (cfg_wr_en) begin
			// Abandon a payload in progress; keep any partial header.
			if (framing_q && !expect_header_q) begin
				expect_header_q <= 1'b1;
				remaining_q     <= '0;
			end
			framing_q <= cfg_wr_data;
		end else if (valid_s1 && advance) begin
			expect_header_q <= expect_header_d;
			digits_q        <= digits_d;
			accum_q         <= accum_d;
			invalid_q       <= invalid_d;
			remaining_q     <= remaining_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			out_valid_q <= emit_c;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_byte_q <= res_byte_c;
			out_last_q <= res_last_c;
			out_kind_q <= res_kind_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = out_byte_q;
	assign frame_last   = out_last_q;
	assign event_kind   = out_kind_q;

endmodule

`default_nettype wire
